### hdl/periodic_task_release_scheduler_top_assert.svh
// Assertion macros shared by the scheduler checker.
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PTRS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler port check failed");

// Consequence must hold in the cycle after the antecedent.
`define PTRS_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler port check failed");

`endif

### hdl/ptrs_pkg.sv
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared types and constants of the periodic task release scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptrs_pkg;

  localparam int DEF_TASK_SLOTS   = 8;
  localparam int DEF_PENDING_BITS = 8;

  localparam int INDEX_W    = 8;
  localparam int PERIOD_W   = 16;
  localparam int TICK_W     = 32;
  localparam int SLOT_OUT_W = 3;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_TRIGGER  = 2'd1,
    MODE_DISPATCH = 2'd2,
    MODE_REGISTER = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_TRIG
  } seq_state_t;

endpackage

`default_nettype wire

### hdl/ptrs_mem.sv
// ----------------------------------------------------------------------------
// ptrs_mem
// Slot table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptrs_mem #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 40
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/ptrs_seq.sv
// ----------------------------------------------------------------------------
// ptrs_seq
// Operation sequencer: write new slot table entries, and read, modify and write back existing ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptrs_seq
  import ptrs_pkg::*;
#(
  parameter int TASK_SLOTS   = DEF_TASK_SLOTS,
  parameter int PENDING_BITS = DEF_PENDING_BITS,
  parameter int SLOT_W       = $clog2(TASK_SLOTS),
  parameter int ENTRY_W      = 2 * PERIOD_W + PENDING_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [1:0]            mode,
  input  wire logic [INDEX_W-1:0]    task_index,
  input  wire logic [PERIOD_W-1:0]   period,
  input  wire logic                  allow_accumulate,
  output logic                       busy,
  output logic                       done,
  output logic                       accepted,
  output logic                       dispatch_valid,
  output logic [SLOT_OUT_W-1:0]      dispatched_slot,
  output logic                       mem_we,
  output logic [SLOT_W-1:0]          mem_waddr,
  output logic [ENTRY_W-1:0]         mem_wdata,
  output logic                       mem_re,
  output logic [SLOT_W-1:0]          mem_raddr,
  input  wire logic [ENTRY_W-1:0]    mem_rdata
);

  localparam logic [SLOT_W-1:0]       LAST     = SLOT_W'(TASK_SLOTS - 1);
  localparam logic [PENDING_BITS-1:0] PEND_MAX = {PENDING_BITS{1'b1}};
  localparam logic [PENDING_BITS-1:0] PEND_ONE = PENDING_BITS'(1);
  localparam logic [INDEX_W-1:0]      SLOT_LIM = INDEX_W'(TASK_SLOTS);

  seq_state_t              state, state_next;
  logic                    sweep_disp, sweep_disp_next;
  logic [SLOT_W-1:0]       rd_cnt, rd_cnt_next;
  logic [SLOT_W-1:0]       pend_addr, pend_addr_next;
  logic                    accum, accum_next;
  logic [TASK_SLOTS-1:0]   slot_reg;
  logic                    reg_set;
  logic                    done_next, accepted_next, dispatch_valid_next;
  logic [SLOT_OUT_W-1:0]   dispatched_slot_next;

  logic [PERIOD_W-1:0]     r_per, r_cd;
  logic [PENDING_BITS-1:0] r_pend, pend_inc;
  logic                    idx_ok;
  logic [SLOT_W-1:0]       idx;

  assign r_per    = mem_rdata[ENTRY_W-1 -: PERIOD_W];
  assign r_cd     = mem_rdata[PENDING_BITS +: PERIOD_W];
  assign r_pend   = mem_rdata[PENDING_BITS-1:0];
  assign pend_inc = (r_pend == PEND_MAX) ? r_pend : r_pend + PEND_ONE;
  assign idx_ok   = task_index < SLOT_LIM;
  assign idx      = task_index[SLOT_W-1:0];
  assign busy     = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      slot_reg       <= '0;
      done           <= 1'b0;
      accepted       <= 1'b0;
      dispatch_valid <= 1'b0;
    end else begin
      state          <= state_next;
      done           <= done_next;
      accepted       <= accepted_next;
      dispatch_valid <= dispatch_valid_next;
      if (reg_set) begin
        slot_reg[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sweep_disp      <= sweep_disp_next;
    rd_cnt          <= rd_cnt_next;
    pend_addr       <= pend_addr_next;
    accum           <= accum_next;
    dispatched_slot <= dispatched_slot_next;
  end

  always_comb begin
    state_next           = state;
    sweep_disp_next      = sweep_disp;
    rd_cnt_next          = rd_cnt;
    pend_addr_next       = pend_addr;
    accum_next           = accum;
    reg_set              = 1'b0;
    done_next            = 1'b0;
    accepted_next        = 1'b0;
    dispatch_valid_next  = 1'b0;
    dispatched_slot_next = '0;
    mem_we               = 1'b0;
    mem_waddr            = pend_addr;
    mem_wdata            = mem_rdata;
    mem_re               = 1'b0;
    mem_raddr            = rd_cnt;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (mode_t'(mode))
            MODE_TICK, MODE_DISPATCH: begin
              // Slot 0 is read now; the sweep then runs one slot a cycle.
              mem_re          = 1'b1;
              mem_raddr       = '0;
              pend_addr_next  = '0;
              rd_cnt_next     = SLOT_W'(1);
              sweep_disp_next = (mode_t'(mode) == MODE_DISPATCH);
              state_next      = ST_SWEEP;
            end
            MODE_TRIGGER: begin
              if (idx_ok && slot_reg[idx]) begin
                mem_re         = 1'b1;
                mem_raddr      = idx;
                pend_addr_next = idx;
                accum_next     = allow_accumulate;
                state_next     = ST_TRIG;
              end else begin
                done_next = 1'b1;
              end
            end
            MODE_REGISTER: begin
              done_next = 1'b1;
              if (idx_ok) begin
                mem_we        = 1'b1;
                mem_waddr     = idx;
                mem_wdata     = {period, period, {PENDING_BITS{1'b0}}};
                reg_set       = 1'b1;
                accepted_next = 1'b1;
              end
            end
          endcase
        end
      end

      ST_SWEEP: begin
        mem_re         = (rd_cnt <= LAST);
        pend_addr_next = rd_cnt;
        rd_cnt_next    = rd_cnt + SLOT_W'(1);
        if (!sweep_disp) begin
          if (slot_reg[pend_addr] && r_cd != '0) begin
            mem_we = 1'b1;
            if (r_cd == PERIOD_W'(1)) begin
              mem_wdata = {r_per, r_per, pend_inc};
            end else begin
              mem_wdata = {r_per, r_cd - PERIOD_W'(1), r_pend};
            end
          end
          if (pend_addr == LAST) begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          if (slot_reg[pend_addr] && r_pend != '0) begin
            mem_we               = 1'b1;
            mem_wdata            = {r_per, r_cd, r_pend - PEND_ONE};
            done_next            = 1'b1;
            dispatch_valid_next  = 1'b1;
            dispatched_slot_next = SLOT_OUT_W'(pend_addr);
            state_next           = ST_IDLE;
          end else if (pend_addr == LAST) begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end

      ST_TRIG: begin
        mem_we        = 1'b1;
        mem_wdata     = {r_per, r_cd, accum ? pend_inc : PEND_ONE};
        accepted_next = 1'b1;
        done_next     = 1'b1;
        state_next    = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/periodic_task_release_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_top
// Periodic task release table with a fixed-priority dispatcher.
// ----------------------------------------------------------------------------
// Usage. A command word (mode, task_index, period, allow_accumulate) is taken
// at a rising edge where start is high and busy is low. Every command gives
// exactly one result word on accepted, dispatch_valid, dispatched_slot and
// tick_count, shown for one cycle while done is high. The receiver cannot
// hold results off, so none is ever queued.
// Path from the accepting edge to the done cycle:
//   register, or any rejected command: the idle state alone,
//   trigger of a registered slot:      the idle and trigger states,
//   tick:                              a sweep of every slot,
//   dispatch:                          a sweep up to the first pending slot.
// The slot table lives in one memory with a single read and a single write
// port; tick and dispatch walk it one slot a cycle, reading slot n while
// slot n-1 is written back, so the walk sets the rate of those commands.
// busy is low again in the done cycle, so a new command may be taken at the
// edge that ends it.
// Reset clears the tick counter, the sequencer and the per-slot registered
// flags at once; table entries of unregistered slots are never consulted,
// so no clearing pass is needed and a command may be given right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_release_scheduler_top
  import ptrs_pkg::*;
#(
  parameter int TASK_SLOTS   = DEF_TASK_SLOTS,
  parameter int PENDING_BITS = DEF_PENDING_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            mode,
  input  wire logic [INDEX_W-1:0]    task_index,
  input  wire logic [PERIOD_W-1:0]   period,
  input  wire logic                  allow_accumulate,
  output logic                       done,
  output logic                       accepted,
  output logic                       dispatch_valid,
  output logic [SLOT_OUT_W-1:0]      dispatched_slot,
  output logic [TICK_W-1:0]          tick_count
);

  // Slot address width and one table entry: period, countdown, pending.
  localparam int SLOT_W  = $clog2(TASK_SLOTS);
  localparam int ENTRY_W = 2 * PERIOD_W + PENDING_BITS;

  logic               mem_we, mem_re;
  logic [SLOT_W-1:0]  mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  // The global tick counter advances as a tick command is taken; it then
  // holds still until the next tick, so it already shows the new count when
  // the tick's result is strobed.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (start && !busy && mode_t'(mode) == MODE_TICK) begin
      tick_count <= tick_count + TICK_W'(1);
    end
  end

  ptrs_seq #(
    .TASK_SLOTS   (TASK_SLOTS),
    .PENDING_BITS (PENDING_BITS),
    .SLOT_W       (SLOT_W),
    .ENTRY_W      (ENTRY_W)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .mode             (mode),
    .task_index       (task_index),
    .period           (period),
    .allow_accumulate (allow_accumulate),
    .busy             (busy),
    .done             (done),
    .accepted         (accepted),
    .dispatch_valid   (dispatch_valid),
    .dispatched_slot  (dispatched_slot),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  ptrs_mem #(
    .DEPTH  (TASK_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

### hdl/ptrs_checker.sv
// ----------------------------------------------------------------------------
// ptrs_checker
// Port-level checks of the scheduler, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_task_release_scheduler_top_assert.svh"

module ptrs_checker
  import ptrs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [1:0]            mode,
  input wire logic                  done,
  input wire logic                  accepted,
  input wire logic                  dispatch_valid,
  input wire logic [SLOT_OUT_W-1:0] dispatched_slot,
  input wire logic [TICK_W-1:0]     tick_count
);

  logic take;
  assign take = start && !busy;

  // A taken command either keeps the block busy or answers in the next cycle.
  `PTRS_ASSERT_NXT(a_take_answers, clk, rst, take, busy || done)
  // A taken tick advances the counter by exactly one.
  `PTRS_ASSERT_NXT(a_tick_inc, clk, rst, take && mode == MODE_TICK,
                   tick_count == $past(tick_count) + TICK_W'(1))
  // Nothing but a tick moves the counter.
  `PTRS_ASSERT_NXT(a_tick_hold, clk, rst, !(take && mode == MODE_TICK), $stable(tick_count))
  // A result never reports both an acceptance and a dispatch.
  `PTRS_ASSERT_IMP(a_one_kind, clk, rst, done, !(accepted && dispatch_valid))
  // An empty dispatch or a non-dispatch result names slot zero.
  `PTRS_ASSERT_IMP(a_slot_zero, clk, rst, done && !dispatch_valid, dispatched_slot == '0)

endmodule

bind periodic_task_release_scheduler_top ptrs_checker u_ptrs_checker (.*);

`default_nettype wire
